[rtl/dcs_pkg.sv]
package dcs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int COORD_WIDTH = 16;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pair;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic  insert;  // new pair enters its sorted place
        logic  shift;   // drain: every cell takes its right neighbour
        t_pair pair;
    } t_cell_ctrl;

    typedef struct packed {
        logic  valid;
        t_pair pair;
    } t_cell_state;

    // descending lexicographic order: true if a must stand before b
    function automatic logic goes_before(input t_pair a, input t_pair b);
        logic r;
        if (a.x != b.x) begin
            r = (a.x > b.x);
        end else begin
            r = (a.y > b.y);
        end
        return r;
    endfunction

endpackage

[rtl/dcs_coord_if.sv]
interface dcs_coord_if;
    logic             valid;
    logic             ready;
    dcs_pkg::t_coord  coord_x;
    dcs_pkg::t_coord  coord_y;
    logic             final_entry;

    modport source (output valid, output coord_x, output coord_y, output final_entry,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input final_entry,
                    output ready);
endinterface

[rtl/dcs_sorted_if.sv]
interface dcs_sorted_if;
    logic             valid;
    logic             ready;
    dcs_pkg::t_coord  sorted_x;
    dcs_pkg::t_coord  sorted_y;
    logic             run_end;
    logic             overflowed;

    modport source (output valid, output sorted_x, output sorted_y, output run_end,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_x, input sorted_y, input run_end,
                    input overflowed, output ready);
endinterface

[rtl/dcs_cell.sv]
module dcs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcs_pkg::t_cell_ctrl  i_ctrl,
    input  dcs_pkg::t_cell_state i_left,
    input  logic                 i_left_disp,
    input  dcs_pkg::t_cell_state i_right,
    output dcs_pkg::t_cell_state o_state,
    output logic                 o_disp
);

    logic          r_valid;
    dcs_pkg::t_pair r_pair;
    logic          n_valid;
    dcs_pkg::t_pair n_pair;

    // this cell's content gives way to the new pair (or the cell is free)
    assign o_disp = !r_valid || dcs_pkg::goes_before(i_ctrl.pair, r_pair);

    always_comb begin
        n_valid = r_valid;
        n_pair  = r_pair;
        if (i_ctrl.shift) begin
            n_valid = i_right.valid;
            n_pair  = i_right.pair;
        end else if (i_ctrl.insert) begin
            n_valid = r_valid || i_left.valid;
            if (o_disp) begin
                n_pair = i_left_disp ? i_left.pair : i_ctrl.pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_pair <= n_pair;
    end

    assign o_state.valid = r_valid;
    assign o_state.pair  = r_pair;

endmodule

[rtl/descending_coordinate_sorter.sv]
// Descending coordinate sorter.
// i_coord (sink): one (coord_x, coord_y) request per accepted cycle; final_entry
//   marks the last pair of a list. o_sorted (source): the stored pairs, greatest
//   x first, equal x by greatest y, equal pairs in arrival order. run_end marks
//   the last result of a run, overflowed is set on every result of a run in
//   which pairs beyond the 64-cell capacity were dropped.
// Insertion: a chain of cells, each comparing the broadcast pair with its own
//   and handing its content to the right-hand neighbour when displaced, so one
//   pair is taken every cycle while loading.
// Output: after the final request sets the drain state, the chain shifts left
//   one cell a cycle into an output register while o_sorted is ready, giving
//   one result per cycle until the chain is empty.
//   i_coord.ready is low while the chain drains; the next list may start once
//   the chain is empty, while the last result still waits in the register.
// A stall on o_sorted simply holds the output register and the chain.
// Reset (synchronous, active low) empties all cells and clears the flags.
module descending_coordinate_sorter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dcs_coord_if.sink     i_coord,
    dcs_sorted_if.source  o_sorted
);

    localparam int N = dcs_pkg::MAX_ENTRIES;

    dcs_pkg::t_cell_state w_state [N];
    logic                 w_disp  [N];
    dcs_pkg::t_cell_ctrl  w_ctrl;
    dcs_pkg::t_pair       w_in_pair;

    logic r_drain, n_drain;
    logic r_drop,  n_drop;
    logic r_run_drop, n_run_drop;

    logic           r_out_valid, n_out_valid;
    dcs_pkg::t_pair r_out_pair,  n_out_pair;
    logic           r_out_end,   n_out_end;
    logic           r_out_ovf,   n_out_ovf;

    logic accept;
    logic full;
    logic load;

    assign w_in_pair.x = i_coord.coord_x;
    assign w_in_pair.y = i_coord.coord_y;

    assign i_coord.ready = !r_drain;
    assign accept        = i_coord.valid && !r_drain;
    assign full          = w_state[N-1].valid;

    // drain step: cell 0 moves into the output register
    assign load = r_drain && w_state[0].valid && (!r_out_valid || o_sorted.ready);

    assign w_ctrl.insert = accept && !full;
    assign w_ctrl.shift  = load;
    assign w_ctrl.pair   = w_in_pair;

    for (genvar g = 0; g < N; g++) begin : g_cell
        dcs_pkg::t_cell_state w_left;
        dcs_pkg::t_cell_state w_right;
        logic                 w_left_disp;

        if (g == 0) begin : g_first
            // head of the chain: the new pair enters here, nothing to its left
            assign w_left.valid = 1'b1;
            assign w_left.pair  = w_in_pair;
            assign w_left_disp  = 1'b0;
        end else begin : g_inner
            assign w_left      = w_state[g-1];
            assign w_left_disp = w_disp[g-1];
        end

        if (g == N - 1) begin : g_last
            assign w_right.valid = 1'b0;
            assign w_right.pair  = w_in_pair;
        end else begin : g_mid
            assign w_right = w_state[g+1];
        end

        dcs_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_left      (w_left),
            .i_left_disp (w_left_disp),
            .i_right     (w_right),
            .o_state     (w_state[g]),
            .o_disp      (w_disp[g])
        );
    end

    always_comb begin
        n_drain     = r_drain;
        n_drop      = r_drop;
        n_run_drop  = r_run_drop;
        n_out_valid = r_out_valid;
        n_out_pair  = r_out_pair;
        n_out_end   = r_out_end;
        n_out_ovf   = r_out_ovf;

        if (o_sorted.ready) begin
            n_out_valid = 1'b0;
        end

        if (accept) begin
            if (full) begin
                n_drop = 1'b1;
            end
            if (i_coord.final_entry) begin
                // freeze the run's overflow flag and open the store for the next run
                n_run_drop = r_drop || full;
                n_drop     = 1'b0;
                n_drain    = 1'b1;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
            n_out_pair  = w_state[0].pair;
            n_out_end   = !w_state[1].valid;
            n_out_ovf   = r_run_drop;
            if (!w_state[1].valid) begin
                n_drain = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain     <= 1'b0;
            r_drop      <= 1'b0;
            r_run_drop  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_drain     <= n_drain;
            r_drop      <= n_drop;
            r_run_drop  <= n_run_drop;
            r_out_valid <= n_out_valid;
        end
        r_out_pair <= n_out_pair;
        r_out_end  <= n_out_end;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_sorted.valid      = r_out_valid;
    assign o_sorted.sorted_x   = r_out_pair.x;
    assign o_sorted.sorted_y   = r_out_pair.y;
    assign o_sorted.run_end    = r_out_end;
    assign o_sorted.overflowed = r_out_ovf;

endmodule
